### sv/ihe_pkg.sv
// shared types and constants for the indexed edge max-heap
`timescale 1ns / 1ps
`default_nettype none
package ihe_pkg;
	localparam int NODE_BITS      = 5;
	localparam int KEY_W          = 2 * NODE_BITS;
	localparam int KEY_COUNT      = 1 << KEY_W;
	localparam int WEIGHT_W       = 32;
	localparam int TOTAL_W        = 9;
	localparam int HEAP_DEPTH_DEF = 256;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_UPDATE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_EMPTY  = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_ABSENT = 3'd3,
		STAT_DUP    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                   opcode;
		logic [NODE_BITS-1:0]  edge_source;
		logic [NODE_BITS-1:0]  edge_dest;
		logic signed [WEIGHT_W-1:0] weight;
	} cmd_beat_t;

	typedef struct packed {
		status_t               status;
		logic [NODE_BITS-1:0]  popped_source;
		logic [NODE_BITS-1:0]  popped_dest;
		logic signed [WEIGHT_W-1:0] popped_weight;
		logic [TOTAL_W-1:0]    entry_total;
	} rsp_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0]           key;
		logic signed [WEIGHT_W-1:0] wt;
	} heap_entry_t;

	localparam int ENTRY_W = $bits(heap_entry_t);
endpackage
`default_nettype wire

### sv/ihe_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ihe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/indexed_max_heap_edges_core.sv
// indexed binary max-heap of weighted edges with in-place weight update
//
//   channel | direction | handshake             | beat
//   cmd     | in        | cmd_valid / cmd_stall | cmd_beat_t
//   rsp     | out       | rsp_valid / rsp_stall | rsp_beat_t
//
// one command at a time; push sifts up, update sifts up or down, and pop sifts down
// with two child reads per level; clear empties the heap
// the single read port of the heap ram makes each read of a level a separate step
// after reset the slot table is swept, all KEY_COUNT (1024) entries, before cmd is taken
// a finished beat waits in the rsp register while the next command is accepted
`timescale 1ns / 1ps
`default_nettype none
module indexed_max_heap_edges_core import ihe_pkg::*; #(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);
	localparam int SW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = SW + 2;

	typedef enum logic [12:0] {
		S_CLEAR   = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_START   = 13'b0000000000100,
		S_SLOT    = 13'b0000000001000,
		S_LOOK    = 13'b0000000010000,
		S_POPTOP  = 13'b0000000100000,
		S_POPLAST = 13'b0000001000000,
		S_UPRD    = 13'b0000010000000,
		S_UPCMP   = 13'b0000100000000,
		S_DNRDA   = 13'b0001000000000,
		S_DNRDB   = 13'b0010000000000,
		S_DNCMP   = 13'b0100000000000,
		S_DONE    = 13'b1000000000000
	} state_t;

	state_t                     state_q;
	logic [KEY_W-1:0]           clr_q;
	logic [CW-1:0]              count_q;
	op_t                        op_q;
	logic [KEY_W-1:0]           key_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic [SW-1:0]              slot_q;
	heap_entry_t                node_q;
	logic [SW-1:0]              i_q;
	logic [SW-1:0]              par_q;
	heap_entry_t                ca_q;
	logic                       hasb_q;
	status_t                    status_q;
	heap_entry_t                pop_q;
	rsp_beat_t                  rsp_q;
	logic                       rsp_valid_q;

	logic              h_we;
	logic [SW-1:0]     h_waddr;
	heap_entry_t       h_wdata;
	logic [SW-1:0]     h_raddr;
	logic [ENTRY_W-1:0] h_rdata;
	logic              s_we;
	logic [KEY_W-1:0]  s_waddr;
	logic [SW-1:0]     s_wdata;
	logic [KEY_W-1:0]  s_raddr;
	logic [SW-1:0]     s_rdata;

	heap_entry_t   hr_ent;
	logic          present;
	logic [XW-1:0] ch_a;
	logic [XW-1:0] ch_b;
	logic [XW-1:0] cnt_x;
	logic [SW-1:0] parent;
	logic          pick_b;
	heap_entry_t   m_ent;
	logic [SW-1:0] m_idx;
	logic          up_move;
	logic          dn_move;

	ihe_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	ihe_ram #(.WIDTH(SW), .DEPTH(KEY_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// an edge is present when its slot is live and that slot holds the edge
	assign hr_ent  = heap_entry_t'(h_rdata);
	assign cnt_x   = XW'(count_q);
	assign present = (XW'(slot_q) < cnt_x) && (hr_ent.key == key_q);
	assign ch_a    = XW'({i_q, 1'b1});
	assign ch_b    = ch_a + XW'(1);
	assign parent  = SW'((i_q - SW'(1)) >> 1);
	assign pick_b  = hasb_q && !(ca_q.wt > hr_ent.wt);
	assign m_ent   = pick_b ? hr_ent : ca_q;
	assign m_idx   = pick_b ? SW'(ch_b) : SW'(ch_a);
	assign up_move = node_q.wt > hr_ent.wt;
	assign dn_move = m_ent.wt > node_q.wt;

	always_comb begin
		h_raddr = '0;
		h_we    = 1'b0;
		h_waddr = i_q;
		h_wdata = node_q;
		s_raddr = key_q;
		s_we    = 1'b0;
		s_waddr = node_q.key;
		s_wdata = i_q;
		unique case (state_q)
			S_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			S_SLOT: begin
				h_raddr = s_rdata;
			end
			S_POPTOP: begin
				h_raddr = SW'(count_q - CW'(1));
			end
			S_UPRD: begin
				h_raddr = parent;
				if (i_q == '0) begin
					h_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_UPCMP: begin
				h_we = 1'b1;
				s_we = 1'b1;
				if (up_move) begin
					h_wdata = hr_ent;
					s_waddr = hr_ent.key;
				end
			end
			S_DNRDA: begin
				h_raddr = SW'(ch_a);
				if (ch_a >= cnt_x) begin
					h_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_DNRDB: begin
				h_raddr = SW'(ch_b);
			end
			S_DNCMP: begin
				h_we = 1'b1;
				s_we = 1'b1;
				if (dn_move) begin
					h_wdata = m_ent;
					s_waddr = m_ent.key;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + KEY_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						op_q     <= cmd.opcode;
						key_q    <= {cmd.edge_source, cmd.edge_dest};
						w_q      <= cmd.weight;
						status_q <= STAT_OK;
						pop_q    <= '0;
						state_q  <= S_START;
					end
				end
				S_START: begin
					unique case (op_q) inside
						OP_PUSH, OP_UPDATE: begin
							state_q <= S_SLOT;
						end
						OP_POP: begin
							if (count_q == '0) begin
								status_q <= STAT_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_POPTOP;
							end
						end
						default: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
					endcase
				end
				S_SLOT: begin
					slot_q  <= s_rdata;
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					node_q.key <= key_q;
					node_q.wt  <= w_q;
					if (op_q == OP_PUSH) begin
						if (present) begin
							status_q <= STAT_DUP;
							state_q  <= S_DONE;
						end else if (count_q == CW'(HEAP_DEPTH)) begin
							status_q <= STAT_FULL;
							state_q  <= S_DONE;
						end else begin
							i_q     <= SW'(count_q);
							count_q <= count_q + CW'(1);
							state_q <= S_UPRD;
						end
					end else begin
						i_q <= slot_q;
						if (!present) begin
							status_q <= STAT_ABSENT;
							state_q  <= S_DONE;
						end else if (w_q > hr_ent.wt) begin
							state_q <= S_UPRD;
						end else if (w_q < hr_ent.wt) begin
							state_q <= S_DNRDA;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_POPTOP: begin
					pop_q   <= hr_ent;
					count_q <= count_q - CW'(1);
					state_q <= S_POPLAST;
				end
				S_POPLAST: begin
					node_q <= hr_ent;
					i_q    <= '0;
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DNRDA;
					end
				end
				S_UPRD: begin
					par_q <= parent;
					if (i_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UPCMP;
					end
				end
				S_UPCMP: begin
					if (up_move) begin
						i_q     <= par_q;
						state_q <= S_UPRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DNRDA: begin
					if (ch_a >= cnt_x) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DNRDB;
					end
				end
				S_DNRDB: begin
					ca_q    <= hr_ent;
					hasb_q  <= ch_b < cnt_x;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (dn_move) begin
						i_q     <= m_idx;
						state_q <= S_DNRDA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status        <= status_q;
						rsp_q.popped_source <= pop_q.key[KEY_W-1:NODE_BITS];
						rsp_q.popped_dest   <= pop_q.key[NODE_BITS-1:0];
						rsp_q.popped_weight <= pop_q.wt;
						rsp_q.entry_total   <= TOTAL_W'(count_q);
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

### sv/ihe_checker.sv
// port-level checks for the indexed edge heap, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ihe_checker import ihe_pkg::*; #(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp
);
	// stalled rsp beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	// one command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second cmd beat taken while busy");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |-> rsp.entry_total == '0)
		else $error("empty status with nonzero total");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.entry_total == TOTAL_W'(HEAP_DEPTH))
		else $error("full status with total below depth");

	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_OK |->
		rsp.popped_source == '0 && rsp.popped_dest == '0 && rsp.popped_weight == '0)
		else $error("popped fields set on error status");
endmodule

bind indexed_max_heap_edges_core ihe_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_ihe_checker (.*);
`default_nettype wire
